// ===== design/ptss_pkg.sv =====
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and codes for the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

   localparam int OPCODE_W    = 2;
   localparam int TIME_W      = 32;
   localparam int KIND_W      = 3;
   localparam int SLOT_IDX_W  = 3;
   localparam int MAX_RESULTS = 8;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CREATE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SET    = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CREATED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NO_SLOT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SET     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

   // read address source for the slot tables
   localparam logic [1:0] RD_FIRST  = 2'd0;
   localparam logic [1:0] RD_NEXT   = 2'd1;
   localparam logic [1:0] RD_TARGET = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [TIME_W-1:0]     now_ms;
      logic [TIME_W-1:0]     interval_ms;
      logic                  want_enabled;
      logic                  run_immediately;
      logic [SLOT_IDX_W-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]     result_kind;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic                  last_of_run;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       req_ready;
      logic       load_req;
      logic       scan_clear;
      logic       rd_en;
      logic [1:0] rd_mode;
      logic       scan_adv;
      logic       fire;
      logic       create;
      logic       set;
      logic       emit_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                req_valid;
      logic [OPCODE_W-1:0] req_op;
      logic                eval_hit;
      logic                idx_last;
      logic                count_full;
      logic                pend_valid;
      logic                out_free;
   } sts_type;

endpackage

// ===== design/ptss_if.sv =====
// ----------------------------------------------------------------------------
// ptss request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface ptss_req_if;
   logic             valid;
   logic             ready;
   ptss_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ptss_rsp_if;
   logic             valid;
   logic             ready;
   ptss_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ptss_ram.sv =====
// ----------------------------------------------------------------------------
// ptss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ptss_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptss_ctrl
// Sequencer for tick scans, task creation and set-state requests.
// ----------------------------------------------------------------------------
module ptss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  ptss_pkg::sts_type sts,
   output ptss_pkg::cmd_type cmd
);
   import ptss_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_TK_START = 3'd1;
   localparam logic [2:0] S_TK_EVAL  = 3'd2;
   localparam logic [2:0] S_TK_END   = 3'd3;
   localparam logic [2:0] S_CREATE   = 3'd4;
   localparam logic [2:0] S_ST_READ  = 3'd5;
   localparam logic [2:0] S_ST_WRITE = 3'd6;
   localparam logic [2:0] S_OTHER    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) begin
               cmd.load_req = 1'b1;
               unique case (sts.req_op)
                  OP_TICK:   state_in = S_TK_START;
                  OP_CREATE: state_in = S_CREATE;
                  OP_SET:    state_in = S_ST_READ;
                  default:   state_in = S_OTHER;
               endcase
            end
         end
         S_TK_START: begin
            cmd.scan_clear = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_mode    = RD_FIRST;
            state_in       = S_TK_EVAL;
         end
         S_TK_EVAL: begin
            // hold while a new hit finds an earlier firing that cannot be handed to the output
            if (!(sts.eval_hit && sts.pend_valid && !sts.out_free)) begin
               cmd.fire = sts.eval_hit;
               if ((sts.eval_hit && sts.count_full) || sts.idx_last) begin
                  state_in = S_TK_END;
               end else begin
                  cmd.scan_adv = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_mode  = RD_NEXT;
               end
            end
         end
         S_TK_END, S_OTHER: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CREATE: begin
            if (sts.out_free) begin
               cmd.create     = 1'b1;
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_ST_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_mode = RD_TARGET;
            state_in    = S_ST_WRITE;
         end
         S_ST_WRITE: begin
            if (sts.out_free) begin
               cmd.set        = 1'b1;
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/ptss_dpath.sv =====
// ----------------------------------------------------------------------------
// ptss_dpath
// Slot tables, scan counters, pending-fire holding and response register.
// ----------------------------------------------------------------------------
module ptss_dpath #(
   parameter int SLOT_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  ptss_pkg::cmd_type cmd,
   output ptss_pkg::sts_type sts,
   input  logic              req_valid,
   input  ptss_pkg::req_type req_payload,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output ptss_pkg::rsp_type rsp_payload
);
   import ptss_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   req_type                 req_ff;
   logic [SLOT_COUNT-1:0]   used_ff, used_in;
   logic [SLOT_COUNT-1:0]   enabled_ff, enabled_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [SLOT_W-1:0]       free_idx_ff, free_idx_in;
   logic                    free_any_ff, free_any_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [SLOT_W-1:0]       target_idx;
   logic                    target_ok;
   logic                    set_ok;
   logic                    create_ok;
   logic [SLOT_W-1:0]       rd_addr;
   logic [TIME_W-1:0]       rd_int;
   logic [TIME_W-1:0]       rd_due;
   logic [TIME_W-1:0]       base_sum;
   logic [TIME_W-1:0]       fire_due;
   logic                    int_wr_en;
   logic                    due_wr_en;
   logic [SLOT_W-1:0]       due_wr_addr;
   logic [TIME_W-1:0]       due_wr_data;
   logic                    out_free;
   logic                    push_pend;
   rsp_type                 final_rsp;

   assign target_idx = SLOT_W'(req_ff.target_slot);
   assign target_ok  = 32'(req_ff.target_slot) < 32'(SLOT_COUNT);
   assign set_ok     = target_ok && used_ff[target_idx];
   assign create_ok  = cmd.create && free_any_ff;

   always_comb begin
      case (cmd.rd_mode)
         RD_FIRST:  rd_addr = '0;
         RD_NEXT:   rd_addr = idx_ff + SLOT_W'(1);
         RD_TARGET: rd_addr = target_idx;
         default:   rd_addr = '0;
      endcase
   end

   // now plus interval: request interval on create, stored interval on set
   assign base_sum = req_ff.now_ms + (cmd.create ? req_ff.interval_ms : rd_int);
   assign fire_due = rd_due + rd_int;

   assign int_wr_en = create_ok;
   assign due_wr_en = cmd.fire || create_ok || (cmd.set && set_ok);

   always_comb begin
      if (cmd.fire) begin
         due_wr_addr = idx_ff;
         due_wr_data = fire_due;
      end else begin
         due_wr_addr = cmd.create ? free_idx_ff : target_idx;
         due_wr_data = req_ff.run_immediately ? req_ff.now_ms : base_sum;
      end
   end

   ptss_ram #(.WIDTH(TIME_W), .DEPTH(SLOT_COUNT)) u_int_ram (
      .clock   (clock),
      .wr_en   (int_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (req_ff.interval_ms),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_int)
   );

   ptss_ram #(.WIDTH(TIME_W), .DEPTH(SLOT_COUNT)) u_due_ram (
      .clock   (clock),
      .wr_en   (due_wr_en),
      .wr_addr (due_wr_addr),
      .wr_data (due_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_due)
   );

   // slot flags
   always_comb begin
      used_in    = used_ff;
      enabled_in = enabled_ff;
      if (create_ok) begin
         used_in[free_idx_ff]    = 1'b1;
         enabled_in[free_idx_ff] = req_ff.want_enabled;
      end
      if (cmd.set && set_ok) begin
         enabled_in[target_idx] = req_ff.want_enabled;
      end
   end

   // lowest free slot, registered
   always_comb begin
      free_any_in = 1'b0;
      free_idx_in = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any_in = 1'b1;
            free_idx_in = SLOT_W'(i);
         end
      end
   end

   // scan position, fire count and the fire held back for its last flag
   always_comb begin
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      if (cmd.scan_clear) begin
         idx_in        = '0;
         count_in      = '0;
         pend_valid_in = 1'b0;
      end else begin
         if (cmd.scan_adv) begin
            idx_in = idx_ff + SLOT_W'(1);
         end
         if (cmd.fire) begin
            count_in      = count_ff + COUNT_W'(1);
            pend_valid_in = 1'b1;
            pend_slot_in  = idx_ff;
         end
      end
   end

   // response register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_pend = cmd.fire && pend_valid_ff;

   always_comb begin
      final_rsp.last_of_run = 1'b1;
      case (req_ff.opcode)
         OP_TICK: begin
            final_rsp.result_kind = pend_valid_ff ? KIND_FIRED : KIND_NONE;
            final_rsp.slot_index  = pend_valid_ff ? SLOT_IDX_W'(pend_slot_ff) : '0;
         end
         OP_CREATE: begin
            final_rsp.result_kind = free_any_ff ? KIND_CREATED : KIND_NO_SLOT;
            final_rsp.slot_index  = free_any_ff ? SLOT_IDX_W'(free_idx_ff) : '0;
         end
         OP_SET: begin
            final_rsp.result_kind = KIND_SET;
            final_rsp.slot_index  = req_ff.target_slot;
         end
         default: begin
            final_rsp.result_kind = KIND_NONE;
            final_rsp.slot_index  = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit_final) begin
         rsp_in       = final_rsp;
         rsp_valid_in = 1'b1;
      end else if (push_pend) begin
         rsp_in.result_kind = KIND_FIRED;
         rsp_in.slot_index  = SLOT_IDX_W'(pend_slot_ff);
         rsp_in.last_of_run = 1'b0;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         enabled_ff    <= '0;
         pend_valid_ff <= 1'b0;
         free_any_ff   <= 1'b1;
         free_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         count_ff      <= '0;
      end else begin
         used_ff       <= used_in;
         enabled_ff    <= enabled_in;
         pend_valid_ff <= pend_valid_in;
         free_any_ff   <= free_any_in;
         free_idx_ff   <= free_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.req_valid  = req_valid;
   assign sts.req_op     = req_payload.opcode;
   assign sts.eval_hit   = used_ff[idx_ff] && enabled_ff[idx_ff] && (rd_due < req_ff.now_ms);
   assign sts.idx_last   = idx_ff == SLOT_W'(SLOT_COUNT - 1);
   assign sts.count_full = count_ff == COUNT_W'(MAX_RESULTS - 1);
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/periodic_task_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Table of periodic task slots: create, set-state and tick-driven firing.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    opcode, now_ms, interval_ms, want_enabled,
//                                   run_immediately, target_slot
//   rsp_chan   out   valid/ready    result_kind, slot_index, last_of_run
//
// One request is worked at a time. A tick walks the slots from slot 0: all
// SLOT_COUNT of them, or fewer once 8 have fired. The slot tables are read
// one slot per cycle through the registered RAM read port while the walk is
// not held by a full response register. Create writes the free slot and its
// response together; set-state first reads the target slot, then writes it.
// Reset frees every slot at once; there is no clearing pass.
//
module periodic_task_slot_scheduler #(
   parameter int SLOT_COUNT = 8
) (
   input  logic          clock,
   input  logic          reset,
   ptss_req_if.sink      req_chan,
   ptss_rsp_if.source    rsp_chan
);
   import ptss_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: accept a request, then walk the slots or update one slot.
   ptss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Datapath: flag bits, interval and due-time RAMs, response register.
   // A fire is held back so that the final one of a tick can carry
   // the last flag; the previous fire goes out when the next one is found.
   ptss_dpath #(.SLOT_COUNT(SLOT_COUNT)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_valid   (req_chan.valid),
      .req_payload (req_chan.payload),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload)
   );

   // Take requests only between operations.
   assign req_chan.ready = cmd.req_ready;

   // A held fire may advance only when the response register can take it.
   a_fire_push_room : assert property (@(posedge clock) disable iff (reset)
      (cmd.fire && sts.pend_valid) |-> sts.out_free)
      else $error("fire pushed a response into a full register");

   // The closing response of a request never overwrites a waiting one.
   a_final_room : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |-> sts.out_free)
      else $error("final response issued while register full");

   // After a request is taken, no second one enters in the next cycle.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

endmodule
